[sv/pwli_pkg.sv]
// Shared types and constants for the piecewise-linear interpolator.
// Holds the stream field layout, opcodes, status codes and the control structs.
// No dependencies.
package pwli_pkg;

  // Width of every value field on the stream ports.
  localparam int FIELD_W = 32;
  // Width of the point index field.
  localparam int IDX_W = 6;
  // Width of the point count register.
  localparam int COUNT_W = 7;
  // Fewest table points that form a segment.
  localparam int MIN_POINTS = 2;

  // Input tdata layout, lowest bit first.
  localparam int IDX_LSB    = 0;
  localparam int PX_LSB     = IDX_LSB + IDX_W;
  localparam int PY_LSB     = PX_LSB + FIELD_W;
  localparam int QX_LSB     = PY_LSB + FIELD_W;
  localparam int IN_USED_W  = QX_LSB + FIELD_W;
  localparam int IN_TDATA_W = ((IN_USED_W + 7) / 8) * 8;

  // Output tdata carries only the interpolated value.
  localparam int OUT_TDATA_W = FIELD_W;

  // Opcodes carried on in_tuser.
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_INTERP = 1'b1;

  // Result status codes carried on out_tuser.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FEW   = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;
  localparam logic [1:0] ST_NOSEG = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_query;   // capture the query abscissa from the input transfer
    logic write_point;  // write the input point into the tables
    logic read_en;      // read both tables at the read address
    logic take_point;   // read data becomes the left end of the segment
    logic load_diff;    // capture segment width, offset and rise
    logic mul_step;     // one shift-add step of the multiplier
    logic div_step;     // one restoring step of the divider
    logic load_out;     // load the output value register
    logic out_ok;       // result is valid, otherwise the value is zero
  } pwli_cmd_t;

  // Comparison flags from the datapath to the controller.
  typedef struct packed {
    logic below_first;  // query lies below the read abscissa
    logic above_last;   // query lies above the read abscissa
    logic hit;          // query lies within the current segment
    logic same_x;       // current segment has zero width
  } pwli_sts_t;

endpackage

[sv/pwli_datapath.sv]
// Datapath of the piecewise-linear interpolator: point tables, segment
// registers, bit-serial multiplier and restoring divider, output value.
// Depends on pwli_pkg.
module pwli_datapath #(
  parameter int MAX_POINTS  = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                                clk,
  input  logic [pwli_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  pwli_pkg::pwli_cmd_t                 cmd,
  input  logic [$clog2(MAX_POINTS)-1:0]       rd_addr,
  output pwli_pkg::pwli_sts_t                 sts,
  output logic [pwli_pkg::OUT_TDATA_W-1:0]    out_value
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam int VW = VALUE_WIDTH;
  localparam int DW = VW + 1;
  localparam int PW = 2 * DW;

  logic signed [VW-1:0] x_mem [MAX_POINTS];
  logic signed [VW-1:0] y_mem [MAX_POINTS];

  logic signed [VW-1:0] x_rd_r;
  logic signed [VW-1:0] y_rd_r;
  logic signed [VW-1:0] query_r;
  logic signed [VW-1:0] x1_r;
  logic signed [VW-1:0] y1_r;
  logic [DW-1:0]        w_r;
  logic [DW-1:0]        mag_r;
  logic                 neg_r;
  logic [PW-1:0]        prod_r;
  logic [PW-1:0]        prod_nxt;
  logic [DW-1:0]        rem_r;
  logic [DW-1:0]        rem_nxt;
  logic [pwli_pkg::OUT_TDATA_W-1:0] out_value_r;

  logic [pwli_pkg::IDX_W-1:0]  wr_idx;
  logic                        wr_idx_ok;
  logic signed [pwli_pkg::FIELD_W-1:0] px_s;
  logic signed [pwli_pkg::FIELD_W-1:0] py_s;
  logic signed [pwli_pkg::FIELD_W-1:0] qx_s;

  logic [DW-1:0]  w_full;
  logic [DW-1:0]  dx_full;
  logic [DW-1:0]  dy_full;
  logic [DW:0]    mul_sum;
  logic [DW:0]    div_sh;
  logic           div_ge;
  logic [DW-1:0]  res_full;
  logic signed [VW-1:0] res_val;

  assign wr_idx    = in_tdata[pwli_pkg::IDX_LSB +: pwli_pkg::IDX_W];
  assign px_s      = in_tdata[pwli_pkg::PX_LSB +: pwli_pkg::FIELD_W];
  assign py_s      = in_tdata[pwli_pkg::PY_LSB +: pwli_pkg::FIELD_W];
  assign qx_s      = in_tdata[pwli_pkg::QX_LSB +: pwli_pkg::FIELD_W];
  assign wr_idx_ok = (32'(wr_idx) < 32'(MAX_POINTS));

  // Table write and registered read; never both in one cycle.
  always_ff @(posedge clk) begin
    if (cmd.write_point && wr_idx_ok) begin
      x_mem[AW'(wr_idx)] <= VW'(px_s);
      y_mem[AW'(wr_idx)] <= VW'(py_s);
    end
    if (cmd.read_en) begin
      x_rd_r <= x_mem[rd_addr];
      y_rd_r <= y_mem[rd_addr];
    end
  end

  // Comparison flags.
  always_comb begin
    sts.below_first = (query_r < x_rd_r);
    sts.above_last  = (query_r > x_rd_r);
    sts.hit         = (query_r >= x1_r) && (query_r <= x_rd_r);
    sts.same_x      = (x_rd_r == x1_r);
  end

  // Segment differences, one bit wider than the values.
  always_comb begin
    w_full  = {x_rd_r[VW-1], x_rd_r} - {x1_r[VW-1], x1_r};
    dx_full = {query_r[VW-1], query_r} - {x1_r[VW-1], x1_r};
    dy_full = {y_rd_r[VW-1], y_rd_r} - {y1_r[VW-1], y1_r};
  end

  // Multiply: shift-add with the offset in the low half of the product.
  // Divide: restoring, quotient bits shift in from the bottom.
  always_comb begin
    mul_sum  = {1'b0, prod_r[PW-1:DW]} + (prod_r[0] ? {1'b0, mag_r} : '0);
    div_sh   = {rem_r, prod_r[PW-1]};
    div_ge   = (div_sh >= {1'b0, w_r});
    prod_nxt = prod_r;
    rem_nxt  = rem_r;
    if (cmd.load_diff) begin
      prod_nxt = {{DW{1'b0}}, dx_full};
      rem_nxt  = '0;
    end else if (cmd.mul_step) begin
      prod_nxt = {mul_sum, prod_r[DW-1:1]};
    end else if (cmd.div_step) begin
      prod_nxt = {prod_r[PW-2:0], div_ge};
      rem_nxt  = div_ge ? DW'(div_sh - {1'b0, w_r}) : div_sh[DW-1:0];
    end
  end

  // The quotient never exceeds the rise, so the result stays within the segment.
  always_comb begin
    res_full = neg_r ? ({y1_r[VW-1], y1_r} - prod_r[DW-1:0])
                     : ({y1_r[VW-1], y1_r} + prod_r[DW-1:0]);
    res_val  = res_full[VW-1:0];
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    rem_r  <= rem_nxt;
    if (cmd.load_query) begin
      query_r <= VW'(qx_s);
    end
    if (cmd.take_point) begin
      x1_r <= x_rd_r;
      y1_r <= y_rd_r;
    end
    if (cmd.load_diff) begin
      w_r   <= w_full;
      neg_r <= dy_full[DW-1];
      mag_r <= dy_full[DW-1] ? (~dy_full + DW'(1)) : dy_full;
    end
    if (cmd.load_out) begin
      out_value_r <= cmd.out_ok ? pwli_pkg::OUT_TDATA_W'(res_val) : '0;
    end
  end

  assign out_value = out_value_r;

endmodule

[sv/pwli_ctrl.sv]
// Controller of the piecewise-linear interpolator: handshakes, point count
// register, table scan sequencing, multiply and divide step counting.
// Depends on pwli_pkg.
module pwli_ctrl #(
  parameter int MAX_POINTS  = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [pwli_pkg::COUNT_W-1:0]       cfg_data,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic                               in_opcode,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [1:0]                         out_status,
  output pwli_pkg::pwli_cmd_t                cmd,
  input  pwli_pkg::pwli_sts_t                sts,
  output logic [$clog2(MAX_POINTS)-1:0]      rd_addr
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam int NW = $clog2(MAX_POINTS + 1);
  localparam int CW = (NW > pwli_pkg::COUNT_W) ? NW : pwli_pkg::COUNT_W;
  localparam int DW = VALUE_WIDTH + 1;
  localparam int PW = 2 * DW;
  localparam int SW = $clog2(PW);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LOAD0 = 3'd1;
  localparam logic [2:0] S_LOADL = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_MUL   = 3'd4;
  localparam logic [2:0] S_DIV   = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0]                   state_r, state_nxt;
  logic [pwli_pkg::COUNT_W-1:0] count_r;
  logic [AW-1:0]                idx_r, idx_nxt;
  logic [SW-1:0]                step_r, step_nxt;
  logic [1:0]                   st_r, st_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [1:0]                   out_status_r;

  logic          in_accept;
  logic          is_interp;
  logic [CW-1:0] count_ext;
  logic [NW-1:0] n_eff;
  logic [AW-1:0] last_idx;

  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == S_IDLE);
  assign in_accept  = in_tvalid && in_tready;
  assign is_interp  = (in_opcode == pwli_pkg::OP_INTERP);
  assign out_tvalid = out_valid_r;
  assign out_status = out_status_r;

  // Point count clamped to the table depth.
  always_comb begin
    count_ext = CW'(count_r);
    n_eff     = (count_ext > CW'(MAX_POINTS)) ? NW'(MAX_POINTS) : NW'(count_ext);
    last_idx  = AW'(n_eff - NW'(1));
  end

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    step_nxt      = step_r;
    st_nxt        = st_r;
    out_valid_nxt = out_valid_r && !out_tready;
    rd_addr       = '0;
    cmd           = '0;
    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          if (is_interp) begin
            cmd.load_query = 1'b1;
            if (n_eff < NW'(pwli_pkg::MIN_POINTS)) begin
              st_nxt    = pwli_pkg::ST_FEW;
              state_nxt = S_DONE;
            end else begin
              cmd.read_en = 1'b1;
              state_nxt   = S_LOAD0;
            end
          end else begin
            cmd.write_point = 1'b1;
          end
        end
      end
      S_LOAD0: begin
        cmd.take_point = 1'b1;
        if (sts.below_first) begin
          st_nxt    = pwli_pkg::ST_RANGE;
          state_nxt = S_DONE;
        end else begin
          cmd.read_en = 1'b1;
          rd_addr     = last_idx;
          state_nxt   = S_LOADL;
        end
      end
      S_LOADL: begin
        if (sts.above_last) begin
          st_nxt    = pwli_pkg::ST_RANGE;
          state_nxt = S_DONE;
        end else begin
          cmd.read_en = 1'b1;
          rd_addr     = AW'(1);
          idx_nxt     = AW'(1);
          state_nxt   = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.hit) begin
          cmd.load_diff = 1'b1;
          st_nxt        = pwli_pkg::ST_OK;
          step_nxt      = '0;
          state_nxt     = sts.same_x ? S_DONE : S_MUL;
        end else if (idx_r == last_idx) begin
          st_nxt    = pwli_pkg::ST_NOSEG;
          state_nxt = S_DONE;
        end else begin
          cmd.take_point = 1'b1;
          cmd.read_en    = 1'b1;
          rd_addr        = AW'(idx_r + AW'(1));
          idx_nxt        = AW'(idx_r + AW'(1));
        end
      end
      S_MUL: begin
        cmd.mul_step = 1'b1;
        step_nxt     = SW'(step_r + SW'(1));
        if (step_r == SW'(DW - 1)) begin
          step_nxt  = '0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        step_nxt     = SW'(step_r + SW'(1));
        if (step_r == SW'(PW - 1)) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          cmd.load_out  = 1'b1;
          cmd.out_ok    = (st_r == pwli_pkg::ST_OK);
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
      step_r      <= '0;
      st_r        <= pwli_pkg::ST_OK;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
      step_r      <= step_nxt;
      st_r        <= st_nxt;
      if (cfg_valid && cfg_ready) begin
        count_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_status_r <= st_r;
    end
  end

  // A result appears only on leaving the completion state.
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_DONE)
    else $error("result raised outside the completion state");

  // The scan index stays within the points in use.
  a_scan_idx: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN |-> (idx_r != '0) && (idx_r <= last_idx))
    else $error("scan index outside the table in use");

  // A zero-width segment bypasses the multiplier and divider.
  a_zero_width: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) && sts.hit && sts.same_x |=> state_r == S_DONE)
    else $error("zero-width segment entered the arithmetic");

  // An interpolation with too few points reports that status at once.
  a_few_points: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && is_interp && (n_eff < NW'(pwli_pkg::MIN_POINTS))
      |=> (state_r == S_DONE) && (st_r == pwli_pkg::ST_FEW))
    else $error("too-few-points status not raised");

  // The divider never runs past its last step.
  a_div_steps: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV |-> step_r <= SW'(PW - 1))
    else $error("divider step count overran");

endmodule

[sv/piecewise_linear_interpolator.sv]
// Piecewise-linear interpolation table: top level joining controller and datapath.
// Depends on pwli_pkg, pwli_ctrl and pwli_datapath.
//
// The block holds a table of up to MAX_POINTS (x, y) points in signed fixed
// point (Q16.16 at the default width) and answers interpolation requests on
// a streaming interface. An input transfer with in_tuser low writes one point
// into the slot given by its index and produces no result; a slot index at or
// beyond MAX_POINTS is ignored. An input transfer with in_tuser high asks for
// the value at query_x and produces exactly one output transfer, whose
// out_tuser gives the status (ok, too few points, out of range, or no
// segment, the last one only for an unsorted table) and whose out_tdata gives
// the interpolated value, or zero on any error. The result is
// y1 + (x - x1) * (y2 - y1) / (x2 - x1) over the first segment that contains
// x, computed with an exact product and a quotient truncated towards zero; a
// zero-width segment returns y1. The number of points in use is set through
// the configuration port and must only be changed while the block is idle;
// values above MAX_POINTS act as MAX_POINTS. Table slots read before they
// have been written give undefined results. An interpolation reads the table
// through a single read port, one point per cycle, then runs a bit-serial
// multiplier and a restoring divider; a zero-width segment and an error
// status skip the arithmetic. The finished result sits in an output
// register, so the next input transfer is taken while it waits to be
// collected.
module piecewise_linear_interpolator #(
  parameter int MAX_POINTS  = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // Configuration: number of points in use.
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [pwli_pkg::COUNT_W-1:0]     cfg_data,      // point_count
  // Input stream.
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [pwli_pkg::IN_TDATA_W-1:0]  in_tdata,      // point_index, point_x, point_y,
                                                          // query_x, zero fill
  input  logic                             in_tuser,      // opcode
  // Result stream.
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [pwli_pkg::OUT_TDATA_W-1:0] out_tdata,     // interp_value
  output logic [1:0]                       out_tuser      // status
);

  pwli_pkg::pwli_cmd_t             cmd;
  pwli_pkg::pwli_sts_t             sts;
  logic [$clog2(MAX_POINTS)-1:0]   rd_addr;

  // The controller owns the handshakes, the point count and all sequencing.
  pwli_ctrl #(
    .MAX_POINTS  (MAX_POINTS),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_opcode  (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_status (out_tuser),
    .cmd        (cmd),
    .sts        (sts),
    .rd_addr    (rd_addr)
  );

  // The datapath holds the tables and does the arithmetic one step per cycle.
  pwli_datapath #(
    .MAX_POINTS  (MAX_POINTS),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .in_tdata  (in_tdata),
    .cmd       (cmd),
    .rd_addr   (rd_addr),
    .sts       (sts),
    .out_value (out_tdata)
  );

endmodule
